// ----- rtl/dtx_pkg.sv -----
package dtx_pkg;

    // default sizes
    localparam int DEF_VEC_BYTES = 64;
    localparam int DEF_NODES     = 64;
    localparam int DEF_CLASSES   = 16;

    // fixed field widths
    localparam int IDX_W      = 6;
    localparam int FIELD_SPAN = 2 ** IDX_W;
    localparam int CLS_W      = 4;
    localparam int OP_W       = 2;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    localparam logic [7:0] FILL_BYTE = 8'hFF;

    typedef enum logic [OP_W-1:0] {
        OP_NODE = 2'd0,
        OP_MASK = 2'd1,
        OP_CHAR = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NODE,
        S_BYTE,
        S_CMP,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0] pos;
        logic [7:0]       thr;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [CLS_W-1:0] cls;
    } t_node;

    localparam int NODE_W = $bits(t_node);

endpackage

// ----- rtl/dtx_ram.sv -----
module dtx_ram
    import dtx_pkg::*;
#(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = DEF_VEC_BYTES,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- rtl/dtx_step.sv -----
module dtx_step
    import dtx_pkg::*;
#(
    parameter  int VEC_BYTES = DEF_VEC_BYTES,
    parameter  int NODES     = DEF_NODES,
    localparam int VW        = $clog2(VEC_BYTES),
    localparam int NW        = $clog2(NODES)
) (
    input  t_node         i_node,
    input  logic [7:0]    i_byte,
    output logic [VW-1:0] o_byte_addr,
    output logic [NW-1:0] o_next
);

    // fold 6-bit fields onto the configured sizes
    logic [VW-1:0]    pos_mod   [FIELD_SPAN];
    logic [NW-1:0]    child_mod [FIELD_SPAN];
    logic [IDX_W-1:0] child;

    for (genvar g = 0; g < FIELD_SPAN; g++) begin : g_tab
        assign pos_mod[g]   = VW'(g % VEC_BYTES);
        assign child_mod[g] = NW'(g % NODES);
    end

    assign o_byte_addr = pos_mod[i_node.pos];
    assign child       = (i_byte <= i_node.thr) ? i_node.left : i_node.right;
    assign o_next      = child_mod[child];

endmodule

// ----- rtl/decision_tree_xor_responder.sv -----
// Write words (tree node, mask byte) and query characters are taken back to back while idle.
// Query end (character word with tlast): walk through node read, byte read and compare states
//   per tree step, at most NODES steps, plus node and byte read of the node it stops at.
// Answer: VEC_BYTES words, one at a time (memory read, then output register), plus stalls.
// Input is held off from query end until the last answer word sits in the output register.
// Reset (sync, active low): FSM, length, wrap flag, vector valid bits, output valid cleared.
module decision_tree_xor_responder
    import dtx_pkg::*;
#(
    parameter int VEC_BYTES = DEF_VEC_BYTES,
    parameter int NODES     = DEF_NODES,
    parameter int CLASSES   = DEF_CLASSES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // node_index, byte_position, threshold, left_child, right_child, is_leaf,
    // leaf_class, byte_index, data_byte, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [OP_W-1:0]       s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_index, out_byte, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // answer_class
    output logic [CLS_W-1:0]      m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int VW         = $clog2(VEC_BYTES);
    localparam int NW         = $clog2(NODES);
    localparam int SW         = $clog2(NODES + 1);
    localparam int MASK_DEPTH = CLASSES * VEC_BYTES;
    localparam int MW         = $clog2(MASK_DEPTH);

    // ---------------------------------------------------------------
    // input word unpack
    // ---------------------------------------------------------------
    logic [IDX_W-1:0] in_node_index;
    logic [IDX_W-1:0] in_byte_pos;
    logic [7:0]       in_thr;
    logic [IDX_W-1:0] in_left;
    logic [IDX_W-1:0] in_right;
    logic             in_leaf;
    logic [CLS_W-1:0] in_cls;
    logic [IDX_W-1:0] in_byte_index;
    logic [7:0]       in_data;
    t_op              in_op;

    assign in_node_index = s_axis_tdata[5:0];
    assign in_byte_pos   = s_axis_tdata[11:6];
    assign in_thr        = s_axis_tdata[19:12];
    assign in_left       = s_axis_tdata[25:20];
    assign in_right      = s_axis_tdata[31:26];
    assign in_leaf       = s_axis_tdata[32];
    assign in_cls        = s_axis_tdata[36:33];
    assign in_byte_index = s_axis_tdata[42:37];
    assign in_data       = s_axis_tdata[50:43];
    assign in_op         = t_op'(s_axis_tuser);

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    t_state            r_state, n_state;
    logic [15:0]       r_count;       // query length, wraps at 64K
    logic              r_wrapped;
    logic [VEC_BYTES-1:0] r_vld;      // vector byte written in this query
    logic [NW-1:0]     r_node;        // current tree node
    logic [SW-1:0]     r_steps;
    logic [CLS_W-1:0]  r_cls;
    logic              r_cls_ok;      // class has masks
    logic [VW-1:0]     r_idx;         // answer position
    logic              r_rd_vld;      // valid bit at vector read address
    logic [7:0]        r_rd_fold;     // length fold at vector read address

    logic              r_ovld;
    logic [CLS_W-1:0]  r_ocls;
    logic [IDX_W-1:0]  r_oidx;
    logic [7:0]        r_obyte;
    logic              r_olast;

    // ---------------------------------------------------------------
    // input decode
    // ---------------------------------------------------------------
    logic        in_acc;
    logic        char_in;
    logic        char_nz;
    logic        query_end;
    logic [15:0] count_inc;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign char_in       = in_acc && (in_op == OP_CHAR);
    assign char_nz       = char_in && (in_data != 8'd0);
    assign query_end     = char_in && s_axis_tlast;
    assign count_inc     = r_count + 16'd1;

    // ---------------------------------------------------------------
    // node table
    // ---------------------------------------------------------------
    logic        node_we;
    t_node       node_wdata;
    t_node       node_q;
    logic [NODE_W-1:0] node_q_raw;

    assign node_we    = in_acc && (in_op == OP_NODE) && (32'(in_node_index) < NODES);
    assign node_wdata = '{pos: in_byte_pos, thr: in_thr, left: in_left, right: in_right,
                          leaf: in_leaf, cls: in_cls};
    assign node_q     = t_node'(node_q_raw);

    dtx_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (NW'(in_node_index)),
        .i_wdata (NODE_W'(node_wdata)),
        .i_raddr (r_node),
        .o_rdata (node_q_raw)
    );

    // ---------------------------------------------------------------
    // class masks
    // ---------------------------------------------------------------
    logic          mask_we;
    logic [MW-1:0] mask_waddr;
    logic [MW-1:0] mask_raddr;
    logic [7:0]    mask_q;

    assign mask_we    = in_acc && (in_op == OP_MASK) && (32'(in_cls) < CLASSES)
                        && (32'(in_byte_index) < VEC_BYTES);
    assign mask_waddr = MW'(32'(in_cls) * VEC_BYTES + 32'(in_byte_index));
    assign mask_raddr = MW'(32'(r_cls) * VEC_BYTES + 32'(r_idx));

    dtx_ram #(
        .WIDTH (8),
        .DEPTH (MASK_DEPTH)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (mask_we),
        .i_waddr (mask_waddr),
        .i_wdata (in_data),
        .i_raddr (mask_raddr),
        .o_rdata (mask_q)
    );

    // ---------------------------------------------------------------
    // query vector; unwritten bytes read as zero through r_vld,
    // the length fold is applied on read instead of stored
    // ---------------------------------------------------------------
    logic          vec_we;
    logic [VW-1:0] vec_waddr;
    logic [VW-1:0] vec_raddr;
    logic [7:0]    vec_q;
    logic [7:0]    eff_byte;
    logic          q_empty;

    assign vec_we    = char_nz && !r_wrapped && (32'(r_count) < VEC_BYTES);
    assign vec_waddr = VW'(r_count);
    assign q_empty   = (r_count == 16'd0) && !r_wrapped;

    dtx_ram #(
        .WIDTH (8),
        .DEPTH (VEC_BYTES)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (vec_waddr),
        .i_wdata (in_data),
        .i_raddr (vec_raddr),
        .o_rdata (vec_q)
    );

    function automatic logic [7:0] fold_byte(input logic [VW-1:0] a,
                                             input logic [15:0]   cnt,
                                             input logic          empty);
        logic [7:0] f;
        f = 8'd0;
        if (empty) begin
            if (a == '0) f = FILL_BYTE;   // empty query marker in byte 0
        end else if (a == VW'(VEC_BYTES - 2)) begin
            f = cnt[7:0];
        end else if (a == VW'(VEC_BYTES - 1)) begin
            f = cnt[15:8];
        end
        return f;
    endfunction

    assign eff_byte = (vec_q & {8{r_rd_vld}}) ^ r_rd_fold;

    // ---------------------------------------------------------------
    // shared node compare unit
    // ---------------------------------------------------------------
    logic [VW-1:0] step_addr;
    logic [NW-1:0] step_next;

    dtx_step #(
        .VEC_BYTES (VEC_BYTES),
        .NODES     (NODES)
    ) u_step (
        .i_node      (node_q),
        .i_byte      (eff_byte),
        .o_byte_addr (step_addr),
        .o_next      (step_next)
    );

    logic emitting;
    assign emitting  = (r_state == S_EMIT_RD) || (r_state == S_EMIT_LD);
    assign vec_raddr = emitting ? r_idx : step_addr;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    logic walk_done;
    logic out_free;
    logic idx_last;
    logic out_load;

    assign walk_done = node_q.leaf || (32'(r_steps) == NODES);
    assign out_free  = !r_ovld || m_axis_tready;
    assign idx_last  = (r_idx == VW'(VEC_BYTES - 1));
    assign out_load  = (r_state == S_EMIT_LD) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (query_end) n_state = S_NODE;
            end
            S_NODE: begin
                n_state = S_BYTE;
            end
            S_BYTE: begin
                n_state = walk_done ? S_EMIT_RD : S_CMP;
            end
            S_CMP: begin
                n_state = S_NODE;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) n_state = idx_last ? S_IDLE : S_EMIT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // length, wrap flag and valid bits; cleared once the last answer word is loaded for output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_wrapped <= 1'b0;
            r_vld     <= '0;
        end else if (out_load && idx_last) begin
            r_count   <= '0;
            r_wrapped <= 1'b0;
            r_vld     <= '0;
        end else begin
            if (char_nz) begin
                r_count <= count_inc;
                if (count_inc == 16'd0) r_wrapped <= 1'b1;
            end
            if (vec_we) r_vld[vec_waddr] <= 1'b1;
        end
    end

    // walk and emit counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node  <= '0;
            r_steps <= '0;
            r_idx   <= '0;
        end else begin
            if (query_end) begin
                r_node  <= '0;
                r_steps <= '0;
            end else if (r_state == S_CMP) begin
                r_node  <= step_next;
                r_steps <= r_steps + SW'(1);
            end
            if (r_state == S_BYTE && walk_done) begin
                r_idx <= '0;
            end else if (out_load && !idx_last) begin
                r_idx <= r_idx + VW'(1);
            end
        end
    end

    // payload side of the walk
    always_ff @(posedge i_clk) begin
        r_rd_vld  <= r_vld[vec_raddr];
        r_rd_fold <= fold_byte(vec_raddr, r_count, q_empty);
        if (r_state == S_BYTE && walk_done) begin
            r_cls    <= node_q.cls;
            r_cls_ok <= (32'(node_q.cls) < CLASSES);
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_load) begin
            r_ovld <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ocls  <= r_cls;
            r_oidx  <= IDX_W'(r_idx);
            r_obyte <= eff_byte ^ (mask_q & {8{r_cls_ok}});
            r_olast <= idx_last;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {{(OUT_DATA_W - IDX_W - 8){1'b0}}, r_obyte, r_oidx};
    assign m_axis_tuser  = r_ocls;
    assign m_axis_tlast  = r_olast;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_last_word_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (r_oidx == IDX_W'(VEC_BYTES - 1)))
        else $error("tlast on a word that is not the last vector byte");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_steps) <= NODES))
        else $error("tree walk ran past the node count");

    a_query_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && idx_last) |=> (r_vld == '0 && r_count == 16'd0 && !r_wrapped
                                     && r_state == S_IDLE))
        else $error("query state not cleared after the answer");

    a_walk_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_end |=> !s_axis_tready)
        else $error("input taken right after a query end");

endmodule

// ----- bench/decision_tree_xor_responder_tb.sv -----
`timescale 1ns / 100ps

module decision_tree_xor_responder_tb;
    import dtx_pkg::*;

    localparam int VB = DEF_VEC_BYTES;
    localparam int NN = DEF_NODES;
    localparam int NC = DEF_CLASSES;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused opcode, dropped by the block

    localparam int QUIET_LIMIT  = 4000;  // walk + 64 answer words under long stalls fit easily
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEM_TARGET  = 320;   // words sent over the whole run, directed part included

    // one input word, fields as the block sees them
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] node;
        logic [IDX_W-1:0] pos;
        logic [7:0]       thr;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [CLS_W-1:0] cls;
        logic [IDX_W-1:0] bidx;
        logic [7:0]       data;
        logic             last;
    } t_cmd_word;

    localparam int CMD_W = $bits(t_cmd_word);

    // one answer word
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [IDX_W-1:0] idx;
        logic [7:0]       val;
        logic             fin;
    } t_answer_word;

    // Shadow of the block: query vector, length, tree and masks. Every accepted
    // word is applied here; a query end queues the 64 answer words it must give.
    class t_answer_scoreboard;
        logic [7:0]   vec [VB];
        logic [15:0]  len;
        bit           wrapped;
        t_node        nodes [NN];
        logic [7:0]   masks [NC][VB];
        t_answer_word pending [$];
        int           errors;

        function new();
            foreach (nodes[i]) nodes[i] = '0;
            foreach (masks[c, b]) masks[c][b] = '0;
            errors = 0;
            clear_query();
        endfunction

        function void clear_query();
            foreach (vec[i]) vec[i] = '0;
            len = '0;
            wrapped = 0;
        endfunction

        // zero is a terminator; past the vector only the length moves
        function void take_char(logic [7:0] c);
            if (c != 8'h00) begin
                if (!wrapped && len < VB) vec[len] = c;
                len = len + 16'd1;
                if (len == 16'd0) wrapped = 1;
            end
        endfunction

        // length goes into the top two bytes; an empty query marks byte 0 instead
        function void fold_length();
            if (len == 16'd0 && !wrapped) begin
                vec[0] = FILL_BYTE;
            end else begin
                vec[VB-2] ^= len[7:0];
                vec[VB-1] ^= len[15:8];
            end
        endfunction

        // walk from the root, give up after NN steps; seen marks every node read
        function int walk_tree(output logic [NN-1:0] seen);
            int n;
            n = 0;
            seen = '0;
            for (int s = 0; s < NN; s++) begin
                seen[n] = 1'b1;
                if (nodes[n].leaf) break;
                n = (vec[nodes[n].pos] <= nodes[n].thr) ? nodes[n].left : nodes[n].right;
            end
            seen[n] = 1'b1;
            return n;
        endfunction

        // class a query would reach if it ended now with character c; state untouched
        function logic [CLS_W-1:0] preview(input logic [7:0] c, output logic [NN-1:0] seen);
            logic [7:0]  keep_vec [VB];
            logic [15:0] keep_len;
            bit          keep_wrapped;
            int          n;
            keep_vec = vec;
            keep_len = len;
            keep_wrapped = wrapped;
            take_char(c);
            fold_length();
            n = walk_tree(seen);
            vec = keep_vec;
            len = keep_len;
            wrapped = keep_wrapped;
            return nodes[n].cls;
        endfunction

        function void note_input(t_cmd_word w);
            int               n;
            logic [NN-1:0]    seen;
            logic [CLS_W-1:0] c;
            t_answer_word     a;
            case (w.op)
                OP_NODE: begin
                    nodes[w.node].pos   = w.pos;
                    nodes[w.node].thr   = w.thr;
                    nodes[w.node].left  = w.left;
                    nodes[w.node].right = w.right;
                    nodes[w.node].leaf  = w.leaf;
                    nodes[w.node].cls   = w.cls;
                end
                OP_MASK: masks[w.cls][w.bidx] = w.data;
                OP_CHAR: begin
                    take_char(w.data);
                    if (w.last) begin
                        fold_length();
                        n = walk_tree(seen);
                        c = nodes[n].cls;
                        for (int i = 0; i < VB; i++) begin
                            a.cls = c;
                            a.idx = IDX_W'(i);
                            a.val = vec[i] ^ masks[c][i];
                            a.fin = (i == VB - 1);
                            pending.push_back(a);
                        end
                        clear_query();
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string field, logic [5:0] at, logic [7:0] want, logic [7:0] got);
            $display("%0t: %s mismatch at answer index %0d, expected %0h, got %0h",
                     $time, field, at, want, got);
            errors++;
        endfunction

        function void check_result(t_answer_word got);
            t_answer_word want;
            if (pending.size() == 0) begin
                $display("%0t: answer word with none expected: class %0h index %0d byte %0h last %0b",
                         $time, got.cls, got.idx, got.val, got.fin);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.cls !== want.cls) report("class", want.idx, 8'(want.cls), 8'(got.cls));
            if (got.idx !== want.idx) report("index", want.idx, 8'(want.idx), 8'(got.idx));
            if (got.val !== want.val) report("byte", want.idx, want.val, got.val);
            if (got.fin !== want.fin) report("tlast", want.idx, 8'(want.fin), 8'(got.fin));
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // node_index, byte_position, threshold, left_child, right_child, is_leaf,
    // leaf_class, byte_index, data_byte, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // opcode
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // out_index, out_byte, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // answer_class
    logic [CLS_W-1:0]      m_axis_tuser;
    logic                  m_axis_tlast;

    t_answer_scoreboard sb = new();

    bit node_set [NN];       // tree entries written so far
    bit mask_set [NC][VB];   // mask bytes written so far
    bit calm = 1'b0;         // no gaps and no stalls while set
    int stall_left = 0;
    int quiet = 0;
    int sent_words = 0;

    decision_tree_xor_responder dut (.*);

    always #10 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // node words carry class 0 or 15; the directed part fills both mask sets,
    // so random trees seldom need a whole class of mask writes
    function automatic t_cmd_word any_word(logic [OP_W-1:0] op);
        t_cmd_word w;
        w = CMD_W'({$urandom, $urandom});
        w.op = op;
        if (op == OP_NODE) w.cls = ($urandom_range(0, 1) != 0) ? '1 : '0;
        return w;
    endfunction

    function automatic t_cmd_word char_word(logic [7:0] c, logic fin);
        t_cmd_word w;
        w = any_word(OP_CHAR);
        w.data = c;
        w.last = fin;
        return w;
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'h00;
        if (r < 15) return 8'hFF;
        if (r < 20) return 8'h01;
        return 8'($urandom_range(1, 255));
    endfunction

    // table write or spare opcode, dropped in between characters
    function automatic logic [OP_W-1:0] stray_op();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) return OP_NODE;
        if (r == 1) return OP_MASK;
        return OP_SPARE;
    endfunction

    task automatic send_word(t_cmd_word w);
        int gap;
        gap = calm ? 0 : idle_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({w.data, w.bidx, w.cls, w.leaf, w.right, w.left,
                                     w.thr, w.pos, w.node});
        s_axis_tuser  <= w.op;
        s_axis_tlast  <= w.last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(w);
        if (w.op == OP_NODE) node_set[w.node] = 1'b1;
        if (w.op == OP_MASK) mask_set[w.cls][w.bidx] = 1'b1;
        sent_words++;
    endtask

    // Before a query ends, write every tree node its walk would read and every
    // mask byte of the class it reaches, so no unwritten entry is ever read.
    task automatic settle_tables(logic [7:0] c);
        logic [NN-1:0]    seen;
        logic [CLS_W-1:0] cls;
        int               hole;
        t_cmd_word        w;
        forever begin
            cls = sb.preview(c, seen);
            hole = -1;
            for (int i = NN - 1; i >= 0; i--)
                if (seen[i] && !node_set[i]) hole = i;
            if (hole < 0) break;
            w = any_word(OP_NODE);
            w.node = IDX_W'(hole);
            w.leaf = ($urandom_range(0, 99) < 40);
            send_word(w);
        end
        for (int b = 0; b < VB; b++) begin
            if (!mask_set[cls][b]) begin
                w = any_word(OP_MASK);
                w.cls = cls;
                w.bidx = IDX_W'(b);
                send_word(w);
            end
        end
    endtask

    // body characters, then the one with tlast; noisy mixes in terminators,
    // table writes and spare opcodes
    task automatic send_query(int body, bit noisy, logic [7:0] final_char);
        logic [7:0] c;
        for (int k = 0; k < body; k++) begin
            if (noisy && $urandom_range(0, 99) < 15) send_word(any_word(stray_op()));
            c = noisy ? pick_char() : 8'($urandom_range(1, 255));
            send_word(char_word(c, 1'b0));
        end
        settle_tables(final_char);
        send_word(char_word(final_char, 1'b1));
    endtask

    // answer side: check every accepted word, then pick next cycle's tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(t_answer_word'({m_axis_tuser, m_axis_tdata[5:0],
                                            m_axis_tdata[13:6], m_axis_tlast}));
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left = idle_length();
            m_axis_tready <= (stall_left == 0);
        end
    end

    // watchdog: too long without a word moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_cmd_word w;
        int        r;
        int        body;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // mask extremes: all zeros at class 0 byte 0, all ones at class 15 byte 63
        w = any_word(OP_MASK);
        w.cls = '0;
        w.bidx = '0;
        w.data = 8'h00;
        send_word(w);
        w.cls = '1;
        w.bidx = '1;
        w.data = 8'hFF;
        send_word(w);

        // root is a leaf of the top class; lone terminator makes an empty query
        w = any_word(OP_NODE);
        w.node = '0;
        w.leaf = 1'b1;
        w.cls = '1;
        send_word(w);
        send_query(0, 1'b0, 8'h00);

        // spare opcode, with and without tlast: nothing comes out
        w = any_word(OP_SPARE);
        w.last = 1'b1;
        send_word(w);
        w.last = 1'b0;
        send_word(w);

        // root tests byte 0 against 0xFE; children with all-zero and all-one fields
        w = any_word(OP_NODE);
        w.node = '0;
        w.pos = '0;
        w.thr = 8'hFE;
        w.left = 6'd1;
        w.right = 6'd2;
        w.leaf = 1'b0;
        send_word(w);
        w = '0;
        w.op = OP_NODE;
        w.node = 6'd1;
        w.leaf = 1'b1;
        send_word(w);
        w = '1;
        w.op = OP_NODE;
        w.node = 6'd2;
        w.last = 1'b0;
        send_word(w);
        send_query(0, 1'b0, 8'hFF);
        send_query(0, 1'b0, 8'hFE);

        // longer than the vector, with terminators and table writes inside
        send_query(80, 1'b1, 8'h00);

        // root points at itself with no leaf: walk stops after NN steps
        w = any_word(OP_NODE);
        w.node = '0;
        w.leaf = 1'b0;
        w.left = '0;
        w.right = '0;
        send_word(w);
        send_query(5, 1'b0, 8'h33);

        // fresh root so the random part grows its own tree
        w = any_word(OP_NODE);
        w.node = '0;
        w.leaf = 1'b0;
        send_word(w);

        // random part: mostly short queries, some long, bursts of table writes
        while (sent_words < ITEM_TARGET) begin
            calm = ($urandom_range(0, 99) < 15);
            r = $urandom_range(0, 99);
            if (r < 75) begin
                r = $urandom_range(0, 99);
                if (r < 85) body = $urandom_range(0, 8);
                else if (r < 97) body = $urandom_range(40, 80);
                else body = $urandom_range(100, 200);
                send_query(body, 1'($urandom_range(0, 1)), pick_char());
            end else begin
                repeat ($urandom_range(1, 4)) send_word(any_word(stray_op()));
            end
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
